// File: hdl/u2u8_pkg.sv
// UTF-16 to UTF-8 transcoder: shared types, constants and the byte encoder.
// Used by every module of the block; no dependencies.

package u2u8_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Most bytes one unit can cause: a flushed surrogate plus a three-byte unit.
  localparam int MAX_BYTES = 6;

  localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;  // 0xDC00..0xDFFF
  localparam logic [20:0] SUPP_BASE     = 21'h10000;
  localparam logic [20:0] LIM_1BYTE     = 21'h00080;
  localparam logic [20:0] LIM_2BYTE     = 21'h00800;
  localparam logic [20:0] LIM_3BYTE     = 21'h10000;
  localparam logic [2:0]  LEAD2_TAG     = 3'b110;
  localparam logic [3:0]  LEAD3_TAG     = 4'b1110;
  localparam logic [4:0]  LEAD4_TAG     = 5'b11110;
  localparam logic [1:0]  CONT_TAG      = 2'b10;

  // One classified unit, as the back end needs it. Part a is a flushed high
  // surrogate (always three bytes), part b the code point of this unit.
  typedef struct packed {
    logic        has_a;
    logic [15:0] cp_a;
    logic        has_b;
    logic [20:0] cp_b;
    logic [2:0]  len_b;
    logic        ends;
  } job_t;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp < LIM_1BYTE)      len = 3'd1;
    else if (cp < LIM_2BYTE) len = 3'd2;
    else if (cp < LIM_3BYTE) len = 3'd3;
    else                     len = 3'd4;
    return len;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (len)
      3'd1: b = cp[7:0];
      3'd2: b = (idx == 3'd0) ? {LEAD2_TAG, cp[10:6]} : {CONT_TAG, cp[5:0]};
      3'd3: begin
        case (idx)
          3'd0:    b = {LEAD3_TAG, cp[15:12]};
          3'd1:    b = {CONT_TAG, cp[11:6]};
          default: b = {CONT_TAG, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          3'd0:    b = {LEAD4_TAG, cp[20:18]};
          3'd1:    b = {CONT_TAG, cp[17:12]};
          3'd2:    b = {CONT_TAG, cp[11:6]};
          default: b = {CONT_TAG, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// File: hdl/u2u8_if.sv
// Stream interfaces of the transcoder: UTF-16 unit channel and UTF-8 byte channel.
// No dependencies.

interface u2u8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

interface u2u8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       text_end;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output text_end, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input run_last,
                input text_end, output ready);
endinterface

// File: hdl/utf16_to_utf8_stream.sv
// UTF-16 to UTF-8 stream transcoder. The front end takes one UTF-16 unit per
// cycle whenever its two-entry job queue has room; the back end sends one UTF-8
// byte per cycle while the byte channel is ready; a unit yields 1 to 4 beats on
// its own, three more when a held high surrogate is flushed ahead of it (so up to
// 6), 1 for an empty end marker, and none for a held high surrogate or a unit
// discarded after a terminator. The byte channel therefore sets the sustained
// rate. A unit's bytes pass through the job queue and the output register.
// Lone surrogates are encoded as three bytes without substitution.
// Depends on u2u8_pkg, u2u8_if, u2u8_front, u2u8_queue and u2u8_back.

module utf16_to_utf8_stream import u2u8_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  u2u8_unit_if.sink   units,
  u2u8_byte_if.source utf8
);

  job_t push_job, head_job;
  logic push, pop, empty, full;

  u2u8_front u_front (
    .clk   (clk),
    .rst   (rst),
    .units (units),
    .full  (full),
    .push  (push),
    .job   (push_job)
  );

  u2u8_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .rd_job (head_job),
    .empty  (empty),
    .full   (full)
  );

  u2u8_back u_back (
    .clk   (clk),
    .rst   (rst),
    .job   (head_job),
    .empty (empty),
    .pop   (pop),
    .utf8  (utf8)
  );

endmodule

// File: hdl/u2u8_front.sv
// Front end: accepts UTF-16 units, tracks surrogate and terminator state, builds jobs.
// Depends on u2u8_pkg and u2u8_unit_if.

module u2u8_front import u2u8_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  u2u8_unit_if.sink   units,
  input  logic        full,
  output logic        push,
  output job_t        job
);

  logic [9:0] held_high, held_high_next;
  logic       held_valid, held_valid_next;
  logic       after_term, after_term_next;
  logic       accept;
  logic       is_high, is_low;

  assign units.ready = !full;
  assign accept      = units.valid && units.ready;
  assign is_high     = units.code_unit[15:10] == SURR_HIGH_TAG;
  assign is_low      = units.code_unit[15:10] == SURR_LOW_TAG;

  always_comb begin
    held_high_next  = held_high;
    held_valid_next = held_valid;
    after_term_next = after_term;
    job             = '0;
    job.cp_a        = {SURR_HIGH_TAG, held_high};
    push            = 1'b0;

    if (after_term) begin
      // discard until the slot marked last
      if (units.last_unit) after_term_next = 1'b0;
    end else begin
      held_valid_next = 1'b0;
      if (held_valid && is_low) begin
        job.has_b = 1'b1;
        job.cp_b  = SUPP_BASE + {1'b0, held_high, units.code_unit[9:0]};
        job.ends  = units.last_unit;
      end else begin
        job.has_a = held_valid;
        if (units.code_unit == 16'h0000) begin
          job.ends        = 1'b1;
          after_term_next = !units.last_unit;
        end else if (is_high && !units.last_unit) begin
          held_high_next  = units.code_unit[9:0];
          held_valid_next = 1'b1;
        end else begin
          job.has_b = 1'b1;
          job.cp_b  = {5'b0, units.code_unit};
          job.ends  = units.last_unit;
        end
      end
      job.len_b = utf8_len(job.cp_b);
      push      = accept && (job.has_a || job.has_b || job.ends);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_high  <= '0;
      held_valid <= 1'b0;
      after_term <= 1'b0;
    end else if (accept) begin
      held_high  <= held_high_next;
      held_valid <= held_valid_next;
      after_term <= after_term_next;
    end
  end

  a_no_hold_after_term: assert property (@(posedge clk) disable iff (rst)
    !(after_term && held_valid))
    else $error("surrogate held while text is terminated");

endmodule

// File: hdl/u2u8_queue.sv
// Job queue between front and back end, two entries in flip-flops.
// Depends on u2u8_pkg.

module u2u8_queue import u2u8_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t rd_job,
  output logic empty,
  output logic full
);

  job_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign empty  = count == '0;
  assign full   = count == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)
        rd_ptr <= (rd_ptr == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("job popped from empty queue");

endmodule

// File: hdl/u2u8_back.sv
// Back end: serialises the queued job into UTF-8 beats through an output register.
// Depends on u2u8_pkg and u2u8_byte_if.

module u2u8_back import u2u8_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  job_t        job,
  input  logic        empty,
  output logic        pop,
  u2u8_byte_if.source utf8
);

  logic       out_valid;
  logic [7:0] out_byte;
  logic       byte_valid, run_last, text_end;
  logic [2:0] pos;
  logic [2:0] a_cnt, total;
  logic [2:0] b_idx;
  logic       job_last, load;
  logic [7:0] cur_byte;

  assign a_cnt    = job.has_a ? 3'd3 : 3'd0;
  assign total    = a_cnt + (job.has_b ? job.len_b : 3'd0);
  // an empty end marker counts as one beat
  assign job_last = (total == 3'd0) || (pos == total - 3'd1);
  assign b_idx    = pos - a_cnt;
  assign load     = !empty && (!out_valid || utf8.ready);
  assign pop      = load && job_last;

  always_comb begin
    if (total == 3'd0)
      cur_byte = 8'h00;
    else if (job.has_a && pos < 3'd3)
      cur_byte = utf8_byte({5'b0, job.cp_a}, 3'd3, pos);
    else
      cur_byte = utf8_byte(job.cp_b, job.len_b, b_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      pos       <= job_last ? 3'd0 : pos + 3'd1;
    end else if (utf8.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= cur_byte;
      byte_valid <= total != 3'd0;
      run_last   <= job_last;
      text_end   <= job_last && job.ends;
    end
  end

  assign utf8.valid      = out_valid;
  assign utf8.out_byte   = out_byte;
  assign utf8.byte_valid = byte_valid;
  assign utf8.run_last   = run_last;
  assign utf8.text_end   = text_end;

  a_marker_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> run_last && text_end)
    else $error("empty marker without end flags");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < 3'(MAX_BYTES))
    else $error("byte position out of range");

endmodule
